>>> sv/aoc_pkg.sv
// ----------------------------------------------------------------------------
// aoc_pkg
// Shared types, constants and helpers for the ARGB over compositor.
// ----------------------------------------------------------------------------
package aoc_pkg;

	localparam int unsigned PIXEL_W   = 32;
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned WEIGHT_W  = CHAN_W + 1;
	localparam int unsigned ALPHA_LSB = 24;

	// Restoring divider: one quotient bit per step, WEIGHT_W steps in total.
	localparam int unsigned DIV_STEPS_PER_STAGE = 3;
	localparam int unsigned DIV_STAGES          = WEIGHT_W / DIV_STEPS_PER_STAGE;

	// Input register, divider stages, blend stage.
	localparam int unsigned AOC_LATENCY = DIV_STAGES + 2;

	localparam logic [CHAN_W-1:0]   ALPHA_OPAQUE = 8'hFF;
	localparam logic [CHAN_W-1:0]   ALPHA_CLEAR  = 8'h00;
	localparam logic [WEIGHT_W-1:0] FULL_WEIGHT  = 9'h100;

	typedef enum logic [1:0] {
		KIND_TOP,
		KIND_BOTTOM,
		KIND_OPAQUE,
		KIND_GENERAL
	} kind_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] top;
		logic [PIXEL_W-1:0] bot;
		kind_t              kind;
		logic [CHAN_W-1:0]  ao;
	} item_t;

	// One color channel weighted toward the top pixel by w out of 256.
	function automatic logic [CHAN_W-1:0] mix_channel(
		input logic [CHAN_W-1:0]   tc,
		input logic [CHAN_W-1:0]   bc,
		input logic [WEIGHT_W-1:0] w
	);
		logic [WEIGHT_W-1:0] wb;
		logic [16:0]         sum;
		wb  = FULL_WEIGHT - w;
		sum = 17'(tc) * 17'(w) + 17'(bc) * 17'(wb);
		return sum[15:8];
	endfunction

endpackage

>>> sv/aoc_div_stage.sv
// ----------------------------------------------------------------------------
// aoc_div_stage
// One registered stage of the weight divider: a few restoring steps.
// ----------------------------------------------------------------------------
module aoc_div_stage
	import aoc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                prev_valid,
	input  item_t               prev_item,
	input  logic [WEIGHT_W-1:0] prev_rem,
	input  logic [WEIGHT_W-1:0] prev_quo,
	output logic                next_valid,
	output item_t               next_item,
	output logic [WEIGHT_W-1:0] next_rem,
	output logic [WEIGHT_W-1:0] next_quo
);

	logic                valid_q;
	item_t               item_q;
	logic [WEIGHT_W-1:0] rem_q;
	logic [WEIGHT_W-1:0] quo_q;

	logic [WEIGHT_W-1:0] rem_d;
	logic [WEIGHT_W-1:0] quo_d;

	// The remainder always stays below the divisor, so doubling it fits in 9 bits.
	always_comb begin
		logic [WEIGHT_W-1:0] divisor;
		logic [WEIGHT_W-1:0] r;
		logic                qb;
		divisor = {1'b0, prev_item.ao};
		r       = prev_rem;
		quo_d   = prev_quo;
		for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
			qb    = (r >= divisor);
			r     = qb ? (r - divisor) : r;
			r     = {r[WEIGHT_W-2:0], 1'b0};
			quo_d = {quo_d[WEIGHT_W-2:0], qb};
		end
		rem_d = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		item_q <= prev_item;
		rem_q  <= rem_d;
		quo_q  <= quo_d;
	end

	assign next_valid = valid_q;
	assign next_item  = item_q;
	assign next_rem   = rem_q;
	assign next_quo   = quo_q;

endmodule

>>> sv/argb_over_composite.sv
// ----------------------------------------------------------------------------
// argb_over_composite
// Porter-Duff over of two non-premultiplied ARGB8888 pixels, top over bottom.
// ----------------------------------------------------------------------------
// A word is taken whenever start is high and busy is low; busy never rises,
// so a new pixel pair may enter on every clock. Each result appears on
// blended_pixel with done high for one cycle, in input order, once its word
// has passed the pipeline: one input stage that forms the output alpha,
// three stages of a restoring divider that produce the 9-bit blend weight
// three bits at a time, and one stage that multiplies and blends the color
// channels.
module argb_over_composite
	import aoc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [PIXEL_W-1:0] top_pixel,
	input  logic [PIXEL_W-1:0] bottom_pixel,
	output logic               done,
	output logic [PIXEL_W-1:0] blended_pixel
);

	logic [CHAN_W-1:0] at_in;
	logic [CHAN_W-1:0] ab_in;
	kind_t             kind_in;
	logic [CHAN_W-1:0] ao_in;

	logic                valid_s1;
	item_t               item_s1;

	logic                valid_s2;
	item_t               item_s2;
	logic [WEIGHT_W-1:0] rem_s2;
	logic [WEIGHT_W-1:0] quo_s2;

	logic                valid_s3;
	item_t               item_s3;
	logic [WEIGHT_W-1:0] rem_s3;
	logic [WEIGHT_W-1:0] quo_s3;

	logic                valid_s4;
	item_t               item_s4;
	logic [WEIGHT_W-1:0] rem_s4;
	logic [WEIGHT_W-1:0] quo_s4;

	logic                valid_s5;
	logic [PIXEL_W-1:0]  pixel_s5;

	logic [PIXEL_W-1:0]  pixel_d;

	assign busy  = 1'b0;
	assign at_in = top_pixel[PIXEL_W-1:ALPHA_LSB];
	assign ab_in = bottom_pixel[PIXEL_W-1:ALPHA_LSB];

	always_comb begin
		if (at_in == ALPHA_OPAQUE || ab_in == ALPHA_CLEAR) begin
			kind_in = KIND_TOP;
		end else if (at_in == ALPHA_CLEAR) begin
			kind_in = KIND_BOTTOM;
		end else if (ab_in == ALPHA_OPAQUE) begin
			kind_in = KIND_OPAQUE;
		end else begin
			kind_in = KIND_GENERAL;
		end
	end

	// Output alpha: (65536 - (256 - at) * (256 - ab)) / 256.
	always_comb begin
		logic [WEIGHT_W-1:0] it;
		logic [WEIGHT_W-1:0] ib;
		logic [16:0]         prod;
		logic [16:0]         diff;
		it    = FULL_WEIGHT - {1'b0, at_in};
		ib    = FULL_WEIGHT - {1'b0, ab_in};
		prod  = 17'(it) * 17'(ib);
		diff  = 17'h10000 - prod;
		ao_in = diff[15:8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		item_s1.top  <= top_pixel;
		item_s1.bot  <= bottom_pixel;
		item_s1.kind <= kind_in;
		item_s1.ao   <= ao_in;
	end

	// Weight = at * 256 / ao; the remainder starts as the top alpha itself.
	aoc_div_stage u_div_a (
		.clk        (clk),
		.arst_n     (arst_n),
		.prev_valid (valid_s1),
		.prev_item  (item_s1),
		.prev_rem   ({1'b0, item_s1.top[PIXEL_W-1:ALPHA_LSB]}),
		.prev_quo   ('0),
		.next_valid (valid_s2),
		.next_item  (item_s2),
		.next_rem   (rem_s2),
		.next_quo   (quo_s2)
	);

	aoc_div_stage u_div_b (
		.clk        (clk),
		.arst_n     (arst_n),
		.prev_valid (valid_s2),
		.prev_item  (item_s2),
		.prev_rem   (rem_s2),
		.prev_quo   (quo_s2),
		.next_valid (valid_s3),
		.next_item  (item_s3),
		.next_rem   (rem_s3),
		.next_quo   (quo_s3)
	);

	aoc_div_stage u_div_c (
		.clk        (clk),
		.arst_n     (arst_n),
		.prev_valid (valid_s3),
		.prev_item  (item_s3),
		.prev_rem   (rem_s3),
		.prev_quo   (quo_s3),
		.next_valid (valid_s4),
		.next_item  (item_s4),
		.next_rem   (rem_s4),
		.next_quo   (quo_s4)
	);

	// The final remainder is not needed; the quotient is the weight, except over an opaque bottom, where the top alpha is.
	always_comb begin
		logic [WEIGHT_W-1:0] w;
		logic [CHAN_W-1:0]   alpha;
		logic                unused_rem;
		unused_rem = ^rem_s4;
		if (item_s4.kind == KIND_OPAQUE) begin
			w     = {1'b0, item_s4.top[PIXEL_W-1:ALPHA_LSB]};
			alpha = ALPHA_OPAQUE;
		end else begin
			w     = quo_s4;
			alpha = item_s4.ao;
		end
		case (item_s4.kind)
			KIND_TOP:    pixel_d = item_s4.top;
			KIND_BOTTOM: pixel_d = item_s4.bot;
			default: begin
				pixel_d = {alpha,
					mix_channel(item_s4.top[23:16], item_s4.bot[23:16], w),
					mix_channel(item_s4.top[15:8],  item_s4.bot[15:8],  w),
					mix_channel(item_s4.top[7:0],   item_s4.bot[7:0],   w)};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		pixel_s5 <= pixel_d;
	end

	assign done          = valid_s5;
	assign blended_pixel = pixel_s5;

endmodule

>>> sv/aoc_checker.sv
// ----------------------------------------------------------------------------
// aoc_checker
// Port-level checks on timing and pass-through cases of the compositor.
// ----------------------------------------------------------------------------
module aoc_checker
	import aoc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [PIXEL_W-1:0] top_pixel,
	input logic [PIXEL_W-1:0] bottom_pixel,
	input logic               done,
	input logic [PIXEL_W-1:0] blended_pixel
);

	logic take;
	assign take = start && !busy;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##AOC_LATENCY done)
		else $error("accepted word produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, AOC_LATENCY))
		else $error("result without an accepted word");

	a_opaque_top: assert property (@(posedge clk) disable iff (!arst_n)
		take && top_pixel[PIXEL_W-1:ALPHA_LSB] == ALPHA_OPAQUE |->
		##AOC_LATENCY blended_pixel == $past(top_pixel, AOC_LATENCY))
		else $error("opaque top pixel not passed through");

	a_clear_top: assert property (@(posedge clk) disable iff (!arst_n)
		take && top_pixel[PIXEL_W-1:ALPHA_LSB] == ALPHA_CLEAR
		&& bottom_pixel[PIXEL_W-1:ALPHA_LSB] != ALPHA_CLEAR |->
		##AOC_LATENCY blended_pixel == $past(bottom_pixel, AOC_LATENCY))
		else $error("transparent top pixel did not yield bottom pixel");

endmodule

bind argb_over_composite aoc_checker u_aoc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.top_pixel     (top_pixel),
	.bottom_pixel  (bottom_pixel),
	.done          (done),
	.blended_pixel (blended_pixel)
);

>>> test/argb_over_composite_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// argb_over_composite_test
// Drives pixel pairs into the ARGB over compositor and checks every blended
// word against a predictor that works the same compositing rule out on its
// own. Directed pairs cover the alpha extremes and every case of the rule.
// Random pairs follow, in phases with different amounts of sender idling.
// ----------------------------------------------------------------------------
module argb_over_composite_test;
	import aoc_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned RANDOM_WORDS = 500;
	localparam int unsigned MAX_REPORTS  = 10;

	typedef struct {
		logic [PIXEL_W-1:0] top;
		logic [PIXEL_W-1:0] bot;
		int unsigned        idle_pct;
	} pixel_pair_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               start         = 1'b0;
	logic [PIXEL_W-1:0] top_pixel     = '0;
	logic [PIXEL_W-1:0] bottom_pixel  = '0;
	logic               busy;
	logic               done;
	logic [PIXEL_W-1:0] blended_pixel;

	pixel_pair_t        pixel_pairs[$];
	logic [PIXEL_W-1:0] pending_blends[$];
	pixel_pair_t        next_pair;
	logic [PIXEL_W-1:0] want_pixel;
	int unsigned        total_words    = 0;
	int unsigned        accepted_words = 0;
	int unsigned        checked_words  = 0;
	int unsigned        errors         = 0;
	int unsigned        cycle_count    = 0;
	int unsigned        kind_seen[4]   = '{0, 0, 0, 0};

	argb_over_composite i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.top_pixel    (top_pixel),
		.bottom_pixel (bottom_pixel),
		.done         (done),
		.blended_pixel(blended_pixel)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The order of these tests decides which case wins when two overlap.
	function automatic kind_t pair_kind(
		input logic [PIXEL_W-1:0] top,
		input logic [PIXEL_W-1:0] bot
	);
		logic [CHAN_W-1:0] at;
		logic [CHAN_W-1:0] ab;
		at = top[ALPHA_LSB +: CHAN_W];
		ab = bot[ALPHA_LSB +: CHAN_W];
		if (at == ALPHA_OPAQUE || ab == ALPHA_CLEAR) begin
			return KIND_TOP;
		end else if (at == ALPHA_CLEAR) begin
			return KIND_BOTTOM;
		end else if (ab == ALPHA_OPAQUE) begin
			return KIND_OPAQUE;
		end
		return KIND_GENERAL;
	endfunction

	function automatic logic [PIXEL_W-1:0] over_pixel(
		input logic [PIXEL_W-1:0] top,
		input logic [PIXEL_W-1:0] bot
	);
		logic [CHAN_W-1:0]  at;
		logic [CHAN_W-1:0]  ab;
		logic [CHAN_W-1:0]  ao;
		int unsigned        coverage;
		int unsigned        w;
		logic [PIXEL_W-1:0] res;
		at = top[ALPHA_LSB +: CHAN_W];
		ab = bot[ALPHA_LSB +: CHAN_W];
		case (pair_kind(top, bot))
			KIND_TOP: begin
				return top;
			end
			KIND_BOTTOM: begin
				return bot;
			end
			KIND_OPAQUE: begin
				ao = ALPHA_OPAQUE;
				w  = at;
			end
			default: begin
				coverage = 65536 - (256 - at) * (256 - ab);
				ao       = CHAN_W'(coverage >> 8);
				// The output alpha is at least one here, since the top alpha is.
				w        = (int'(at) << 8) / ao;
				if (w > FULL_WEIGHT) begin
					w = FULL_WEIGHT;
				end
			end
		endcase
		res = '0;
		res[ALPHA_LSB +: CHAN_W] = ao;
		for (int i = 0; i < 3; i++) begin
			res[CHAN_W*i +: CHAN_W] = CHAN_W'((top[CHAN_W*i +: CHAN_W] * w +
				bot[CHAN_W*i +: CHAN_W] * (FULL_WEIGHT - w)) >> 8);
		end
		return res;
	endfunction

	function automatic logic [CHAN_W-1:0] pick_alpha();
		case ($urandom_range(0, 9))
			0: return ALPHA_CLEAR;
			1: return ALPHA_OPAQUE;
			2: return 8'h01;
			3: return 8'hFE;
			default: return CHAN_W'($urandom);
		endcase
	endfunction

	task automatic add_pair(
		input logic [PIXEL_W-1:0] top,
		input logic [PIXEL_W-1:0] bot,
		input int unsigned        idle_pct
	);
		pixel_pair_t p;
		p.top      = top;
		p.bot      = bot;
		p.idle_pct = idle_pct;
		pixel_pairs.push_back(p);
		total_words++;
	endtask

	task automatic note_failure(input string what);
		errors++;
		if (errors <= MAX_REPORTS) begin
			$display("[%0t] %s", $realtime, what);
		end
	endtask

	// Driver: a word stays on the ports until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start        <= 1'b0;
			top_pixel    <= '0;
			bottom_pixel <= '0;
		end else begin
			if (start && !busy) begin
				pending_blends.push_back(over_pixel(top_pixel, bottom_pixel));
				kind_seen[int'(pair_kind(top_pixel, bottom_pixel))]++;
				accepted_words++;
			end
			if (!(start && busy)) begin
				if (pixel_pairs.size() != 0 &&
				    $urandom_range(0, 99) >= pixel_pairs[0].idle_pct) begin
					next_pair     = pixel_pairs.pop_front();
					start        <= 1'b1;
					top_pixel    <= next_pair.top;
					bottom_pixel <= next_pair.bot;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every blended word must match the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_blends.size() == 0) begin
				note_failure($sformatf("unexpected word %08h", blended_pixel));
			end else begin
				want_pixel = pending_blends.pop_front();
				checked_words++;
				if (blended_pixel !== want_pixel) begin
					note_failure($sformatf("blended_pixel expected %08h, got %08h",
						want_pixel, blended_pixel));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d words outstanding.",
				cycle_count, pending_blends.size());
			$display("argb_over_composite regression: fail");
			$finish;
		end
	end

	initial begin
		int unsigned phase_idle[3] = '{0, 75, 33};
		// Directed pairs: alpha extremes, each case, and the overlaps between them.
		add_pair(32'hFFFFFFFF, 32'h00000000, 0);
		add_pair(32'hFF123456, 32'h80ABCDEF, 0);
		add_pair(32'h00FFFFFF, 32'h00000000, 0);
		add_pair(32'h00A5A5A5, 32'h7F5A5A5A, 0);
		add_pair(32'h00000000, 32'hFFFFFFFF, 0);
		add_pair(32'h00FFFFFF, 32'hFF000000, 0);
		add_pair(32'h01FFFFFF, 32'hFF000000, 0);
		add_pair(32'hFEFFFFFF, 32'hFF000000, 0);
		add_pair(32'h80000000, 32'hFFFFFFFF, 0);
		add_pair(32'h01000000, 32'hFFFFFFFF, 0);
		add_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 0);
		add_pair(32'h01FFFFFF, 32'h01000000, 0);
		add_pair(32'hFEFFFFFF, 32'hFE000000, 0);
		add_pair(32'h01000000, 32'hFEFFFFFF, 0);
		add_pair(32'hFE000000, 32'h01FFFFFF, 0);
		add_pair(32'h7FFFFFFF, 32'h80000000, 0);
		add_pair(32'h80FF00FF, 32'h01123456, 0);
		add_pair(32'h80C0FFEE, 32'h40123456, 0);
		add_pair(32'hFE00FF00, 32'h02FF00FF, 0);
		add_pair(32'h55AA55AA, 32'hAA55AA55, 0);
		// Random pairs, with alphas weighted toward the case boundaries.
		for (int ph = 0; ph < 3; ph++) begin
			for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
				add_pair({pick_alpha(), 24'($urandom)}, {pick_alpha(), 24'($urandom)},
					phase_idle[ph]);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_words < total_words) @(posedge clk);
		while (pending_blends.size() != 0) @(posedge clk);
		repeat (AOC_LATENCY + 4) @(posedge clk);
		if (pending_blends.size() != 0) begin
			note_failure($sformatf("%0d words never arrived", pending_blends.size()));
		end

		$display("Composited %0d pixel pairs: %0d top kept, %0d bottom kept, %0d over opaque,",
			accepted_words, kind_seen[int'(KIND_TOP)], kind_seen[int'(KIND_BOTTOM)],
			kind_seen[int'(KIND_OPAQUE)]);
		$display("%0d general blends; %0d words checked, %0d failures, sender idling 0/75/33.",
			kind_seen[int'(KIND_GENERAL)], checked_words, errors);
		if (errors == 0) begin
			$display("argb_over_composite regression: pass");
		end else begin
			$display("argb_over_composite regression: fail");
		end
		$finish;
	end

endmodule
